>>> rtl/m68kpd_pkg.sv
`default_nettype none
package m68kpd_pkg;

  localparam logic [15:0] OpRts      = 16'h4E75;
  localparam logic [15:0] OpRte      = 16'h4E73;
  localparam logic [15:0] OpRtr      = 16'h4E77;
  localparam logic [15:0] OpStop     = 16'h4E72;
  localparam logic [15:0] OpNop      = 16'h4E71;
  localparam logic [15:0] OpReset    = 16'h4E70;
  localparam logic [15:0] OpTrapv    = 16'h4E76;
  localparam logic [15:0] OpLink     = 16'h4E50;
  localparam logic [15:0] OpUnlk     = 16'h4E58;
  localparam logic [15:0] OpTrap     = 16'h4E40;
  localparam logic [15:0] OpMoveUsp  = 16'h4E60;
  localparam logic [15:0] OpJmp      = 16'h4EC0;
  localparam logic [15:0] OpJsr      = 16'h4E80;
  localparam logic [15:0] OpSwap     = 16'h4840;
  localparam logic [15:0] OpExt      = 16'h4880;
  localparam logic [15:0] OpLea      = 16'h41C0;
  localparam logic [15:0] OpMovem    = 16'h4880;
  localparam logic [15:0] MaskMovem  = 16'hFB80;
  localparam logic [15:0] OpMoveSr   = 16'h40C0;
  localparam logic [15:0] OpMoveCcr  = 16'h44C0;
  localparam logic [15:0] OpMoveToSr = 16'h46C0;
  localparam logic [15:0] OpChk      = 16'h4100;
  localparam logic [15:0] MaskChk    = 16'hF140;
  localparam logic [15:0] OpMovep    = 16'h0108;
  localparam logic [15:0] MaskMovep  = 16'hF138;

  // EA size codes
  localparam logic [1:0] SzByte = 2'd0;
  localparam logic [1:0] SzWord = 2'd1;
  localparam logic [1:0] SzLong = 2'd2;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] opcode_word;
    logic [15:0] ext_word_one;
    logic [15:0] ext_word_two;
    logic [15:0] ext_word_three;
    logic [15:0] ext_word_four;
    logic [2:0]  words_available;
  } item_t;

  typedef struct packed {
    logic [3:0]  length_bytes;
    logic        valid_res;
    logic        is_branch;
    logic        is_call;
    logic        is_return;
    logic        is_conditional;
    logic        has_target;
    logic [31:0] branch_target;
  } res_t;

  typedef struct packed {
    logic [1:0] words;
    logic       bad;
  } ea_t;

  // Extension words taken by one effective address.
  function automatic ea_t ea_len(logic [2:0] mode, logic [2:0] rg, logic [1:0] size);
    ea_t r;
    r = '{words: 2'd0, bad: 1'b0};
    if (mode == 3'd5 || mode == 3'd6) begin
      r.words = 2'd1;
    end else if (mode == 3'd7) begin
      unique case (rg)
        3'd0, 3'd2, 3'd3: r.words = 2'd1;
        3'd1:             r.words = 2'd2;
        3'd4:             r.words = (size == SzLong) ? 2'd2 : 2'd1;
        default:          r.bad = 1'b1;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/m68kpd_if.sv
`default_nettype none
interface m68kpd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [15:0] opcode_word;
  logic [15:0] ext_word_one;
  logic [15:0] ext_word_two;
  logic [15:0] ext_word_three;
  logic [15:0] ext_word_four;
  logic [2:0]  words_available;

  modport source (output valid, address, opcode_word, ext_word_one, ext_word_two,
                  ext_word_three, ext_word_four, words_available, input ready);
  modport sink (input valid, address, opcode_word, ext_word_one, ext_word_two,
                ext_word_three, ext_word_four, words_available, output ready);
endinterface

interface m68kpd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  length_bytes;
  logic        valid_res;
  logic        is_branch;
  logic        is_call;
  logic        is_return;
  logic        is_conditional;
  logic        has_target;
  logic [31:0] branch_target;

  modport source (output valid, length_bytes, valid_res, is_branch, is_call, is_return,
                  is_conditional, has_target, branch_target, input ready);
  modport sink (input valid, length_bytes, valid_res, is_branch, is_call, is_return,
                is_conditional, has_target, branch_target, output ready);
endinterface
`default_nettype wire

>>> rtl/m68000_instruction_predecoder_top.sv
// Each accepted input beat is decoded from the input register into the result register.
// Throughput: one instruction per cycle unless out_o stalls; the decode and the 32-bit
//   target adder sit between the input register and the result register.
// Reset: rst_ni is asynchronous, active low; it empties both stages, payload is not reset.
`default_nettype none
module m68000_instruction_predecoder_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  m68kpd_in_if.sink     in_i,
  m68kpd_out_if.source  out_o
);

  // Stage 1: input register. Stage 2: result register.
  logic              s1_valid_q, s1_valid_d;
  logic              s2_valid_q, s2_valid_d;
  m68kpd_pkg::item_t s1_item_q, in_item;
  m68kpd_pkg::res_t  s2_res_q, dec_res;
  logic              s2_take, s1_take;

  // Advance stage 2 whenever it is empty or its beat leaves this cycle.
  assign s2_take = !s2_valid_q || out_o.ready;
  // Stage 1 frees up when its item moves to stage 2.
  assign s1_take = !s1_valid_q || s2_take;
  assign in_i.ready = s1_take;

  assign in_item = '{address:         in_i.address,
                     opcode_word:     in_i.opcode_word,
                     ext_word_one:    in_i.ext_word_one,
                     ext_word_two:    in_i.ext_word_two,
                     ext_word_three:  in_i.ext_word_three,
                     ext_word_four:   in_i.ext_word_four,
                     words_available: in_i.words_available};

  assign s1_valid_d = s1_take ? in_i.valid : s1_valid_q;
  assign s2_valid_d = s2_take ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Hold payloads unless the stage advances.
  always_ff @(posedge clk_i) begin
    if (s1_take && in_i.valid) s1_item_q <= in_item;
    if (s2_take && s1_valid_q) s2_res_q <= dec_res;
  end

  m68kpd_decode u_decode (
    .item_i (s1_item_q),
    .res_o  (dec_res)
  );

  assign out_o.valid          = s2_valid_q;
  assign out_o.length_bytes   = s2_res_q.length_bytes;
  assign out_o.valid_res      = s2_res_q.valid_res;
  assign out_o.is_branch      = s2_res_q.is_branch;
  assign out_o.is_call        = s2_res_q.is_call;
  assign out_o.is_return      = s2_res_q.is_return;
  assign out_o.is_conditional = s2_res_q.is_conditional;
  assign out_o.has_target     = s2_res_q.has_target;
  assign out_o.branch_target  = s2_res_q.branch_target;

endmodule
`default_nettype wire

>>> rtl/m68kpd_decode.sv
`default_nettype none
module m68kpd_decode (
  input  m68kpd_pkg::item_t item_i,
  output m68kpd_pkg::res_t  res_o
);

  logic [15:0] op;
  logic [3:0]  line;
  logic [2:0]  mode, rg, grp, opm;
  logic [1:0]  sz;
  logic [2:0]  avail;
  logic [2:0]  need;
  logic        bad, handled, br, call, ret, cond, tgt_ok;
  logic [31:0] disp;
  logic [31:0] pc_next;
  logic [31:0] sx_one;
  m68kpd_pkg::ea_t ea_a, ea_b;

  assign op      = item_i.opcode_word;
  assign line    = op[15:12];
  assign mode    = op[5:3];
  assign rg      = op[2:0];
  assign grp     = op[11:9];
  assign opm     = op[8:6];
  assign sz      = op[7:6];
  assign avail   = (item_i.words_available > 3'd5) ? 3'd5 : item_i.words_available;
  assign pc_next = item_i.address + 32'd2;
  assign sx_one  = {{16{item_i.ext_word_one[15]}}, item_i.ext_word_one};

  always_comb begin
    need    = 3'd1;
    bad     = 1'b0;
    handled = 1'b0;
    br      = 1'b0;
    call    = 1'b0;
    ret     = 1'b0;
    cond    = 1'b0;
    tgt_ok  = 1'b0;
    disp    = sx_one;
    ea_a    = '{words: 2'd0, bad: 1'b0};
    ea_b    = '{words: 2'd0, bad: 1'b0};
    unique case (line)
      4'h1, 4'h2, 4'h3: begin
        ea_a = m68kpd_pkg::ea_len(mode, rg, (line == 4'h1) ? m68kpd_pkg::SzByte :
                                  (line == 4'h2) ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord);
        ea_b = m68kpd_pkg::ea_len(opm, grp, (line == 4'h1) ? m68kpd_pkg::SzByte :
                                  (line == 4'h2) ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord);
        handled = 1'b1;
      end
      4'h7: handled = !op[8];
      4'h6: begin
        if (op[7:0] == 8'h00) begin
          need = 3'd2;
        end else if (op[7:0] == 8'hFF) begin
          need = 3'd3;
          disp = {item_i.ext_word_one, item_i.ext_word_two};
        end else begin
          disp = {{24{op[7]}}, op[7:0]};
        end
        tgt_ok  = 1'b1;
        br      = 1'b1;
        call    = (op[11:8] == 4'd1);
        cond    = (op[11:8] >= 4'd2);
        handled = 1'b1;
      end
      4'h5: begin
        if (sz == 2'd3) begin
          if (mode == 3'd1) begin
            need   = 3'd2;
            tgt_ok = 1'b1;
            br     = 1'b1;
          end else begin
            ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzByte);
          end
          cond = 1'b1;
        end else begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, sz);
        end
        handled = 1'b1;
      end
      4'h0: begin
        priority if ((op & m68kpd_pkg::MaskMovep) == m68kpd_pkg::OpMovep) begin
          need    = 3'd2;
          handled = 1'b1;
        end else if (op[8] || grp == 3'd4) begin
          if (grp == 3'd4 && !op[8]) need = 3'd2;
          ea_a = m68kpd_pkg::ea_len(mode, rg, (mode == 3'd0) ? m68kpd_pkg::SzLong :
                                    m68kpd_pkg::SzByte);
          handled = 1'b1;
        end else if (grp != 3'd7 && sz != 2'd3) begin
          need = (sz == m68kpd_pkg::SzLong) ? 3'd3 : 3'd2;
          if (!(mode == 3'd7 && rg == 3'd4 && (grp == 3'd0 || grp == 3'd1 || grp == 3'd5)
                && sz <= 2'd1))
            ea_a = m68kpd_pkg::ea_len(mode, rg, sz);
          handled = 1'b1;
        end else begin
          handled = 1'b0;
        end
      end
      4'h4: begin
        handled = 1'b1;
        priority if ((op & 16'hFFF8) == m68kpd_pkg::OpLink) begin
          need = 3'd2;
        end else if ((op & 16'hFFF8) == m68kpd_pkg::OpUnlk ||
                     (op & 16'hFFF0) == m68kpd_pkg::OpTrap ||
                     op == m68kpd_pkg::OpNop || op == m68kpd_pkg::OpReset ||
                     op == m68kpd_pkg::OpTrapv) begin
          need = 3'd1;
        end else if (op == m68kpd_pkg::OpRte || op == m68kpd_pkg::OpRts ||
                     op == m68kpd_pkg::OpRtr) begin
          ret = 1'b1;
          br  = 1'b1;
        end else if (op == m68kpd_pkg::OpStop) begin
          need = 3'd2;
        end else if ((op & 16'hFFF0) == m68kpd_pkg::OpMoveUsp) begin
          need = 3'd1;
        end else if ((op & 16'hFFC0) == m68kpd_pkg::OpJmp ||
                     (op & 16'hFFC0) == m68kpd_pkg::OpJsr) begin
          ea_a   = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzLong);
          tgt_ok = (mode == 3'd7 && rg == 3'd2);
          br     = 1'b1;
          call   = ((op & 16'hFFC0) == m68kpd_pkg::OpJsr);
        end else if ((op & 16'hFFF8) == m68kpd_pkg::OpSwap ||
                     (op & 16'hFFB8) == m68kpd_pkg::OpExt) begin
          need = 3'd1;
        end else if ((op & 16'hFFC0) == m68kpd_pkg::OpSwap ||
                     (op & 16'hF1C0) == m68kpd_pkg::OpLea) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzLong);
        end else if ((op & m68kpd_pkg::MaskMovem) == m68kpd_pkg::OpMovem) begin
          need = 3'd2;
          ea_a = m68kpd_pkg::ea_len(mode, rg, op[6] ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord);
        end else if ((op & 16'hFFC0) == m68kpd_pkg::OpMoveSr ||
                     (op & 16'hFFC0) == m68kpd_pkg::OpMoveCcr ||
                     (op & 16'hFFC0) == m68kpd_pkg::OpMoveToSr) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzWord);
        end else if (op[11:8] == 4'h2 || op[11:8] == 4'h4 ||
                     op[11:8] == 4'h0 || op[11:8] == 4'h6) begin
          if (sz == 2'd3) handled = 1'b0;
          else ea_a = m68kpd_pkg::ea_len(mode, rg, sz);
        end else if (op[11:8] == 4'hA) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, (sz == 2'd3) ? m68kpd_pkg::SzByte : sz);
        end else if ((op & m68kpd_pkg::MaskChk) == m68kpd_pkg::OpChk) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzWord);
        end else begin
          handled = 1'b0;
        end
      end
      4'h8, 4'h9, 4'hB, 4'hC, 4'hD: begin
        handled = 1'b1;
        priority if ((line == 4'h9 || line == 4'hD || line == 4'hB) &&
                     (opm == 3'd3 || opm == 3'd7)) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, (opm == 3'd7) ? m68kpd_pkg::SzLong :
                                    m68kpd_pkg::SzWord);
        end else if ((line == 4'hC || line == 4'h8) && (opm == 3'd3 || opm == 3'd7)) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzWord);
        end else if (line == 4'hC && (op & 16'h0130) == 16'h0100 &&
                     (op[7:3] == 5'b01000 || op[7:3] == 5'b01001 || op[7:3] == 5'b10001)) begin
          need = 3'd1; // EXG
        end else if (line == 4'hB && (op & 16'h0138) == 16'h0108) begin
          need = 3'd1; // CMPM
        end else if (line == 4'hB && opm[2]) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, opm[1:0]);
        end else if ((line == 4'h9 || line == 4'hD) && opm[2] && mode <= 3'd1) begin
          need = 3'd1; // ADDX/SUBX
        end else if ((line == 4'hC || line == 4'h8) && (op & 16'h01F0) == 16'h0100) begin
          need = 3'd1; // ABCD/SBCD
        end else if (opm[1:0] != 2'd3) begin
          ea_a = m68kpd_pkg::ea_len(mode, rg, opm[1:0]);
        end else begin
          handled = 1'b0;
        end
      end
      4'hE: begin
        if (sz == 2'd3) ea_a = m68kpd_pkg::ea_len(mode, rg, m68kpd_pkg::SzWord);
        handled = 1'b1;
      end
      default: handled = 1'b0;
    endcase
    need = need + {1'b0, ea_a.words} + {1'b0, ea_b.words};
    bad  = ea_a.bad || ea_b.bad || (need > avail);
  end

  logic ok;
  assign ok = handled && !bad;

  always_comb begin
    res_o                = '0;
    res_o.length_bytes   = 4'd2;
    if (ok) begin
      res_o.length_bytes   = {need, 1'b0};
      res_o.valid_res      = 1'b1;
      res_o.is_branch      = br;
      res_o.is_call        = call;
      res_o.is_return      = ret;
      res_o.is_conditional = cond;
      res_o.has_target     = tgt_ok;
      res_o.branch_target  = tgt_ok ? pc_next + disp : 32'd0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/m68kpd_chk.sv
`default_nettype none
module m68kpd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [3:0]  length_bytes_i,
  input wire logic        valid_res_i,
  input wire logic        is_branch_i,
  input wire logic        is_call_i,
  input wire logic        is_return_i,
  input wire logic        has_target_i,
  input wire logic [31:0] branch_target_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(branch_target_i))
    else $error("result beat dropped or changed while stalled");

  a_invalid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> length_bytes_i == 4'd2 && !is_branch_i && !has_target_i)
    else $error("invalid result not in fallback form");

  a_target_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_target_i |-> is_branch_i && !is_return_i)
    else $error("target without branch");

  a_call_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (is_call_i || is_return_i) |-> is_branch_i && !(is_call_i && is_return_i))
    else $error("call or return flag inconsistent");

endmodule

bind m68000_instruction_predecoder_top m68kpd_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .length_bytes_i  (out_o.length_bytes),
  .valid_res_i     (out_o.valid_res),
  .is_branch_i     (out_o.is_branch),
  .is_call_i       (out_o.is_call),
  .is_return_i     (out_o.is_return),
  .has_target_i    (out_o.has_target),
  .branch_target_i (out_o.branch_target)
);
`default_nettype wire

>>> test/tb_m68000_instruction_predecoder_top.sv
`default_nettype none
module tb_m68000_instruction_predecoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  m68kpd_in_if  in_bus ();
  m68kpd_out_if out_bus ();

  m68000_instruction_predecoder_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Line numbers of the opcode map (top nibble of the opcode word).
  localparam logic [3:0] LineBitImm = 4'h0;
  localparam logic [3:0] LineMoveB  = 4'h1;
  localparam logic [3:0] LineMoveL  = 4'h2;
  localparam logic [3:0] LineMoveW  = 4'h3;
  localparam logic [3:0] LineMisc   = 4'h4;
  localparam logic [3:0] LineQuick  = 4'h5;
  localparam logic [3:0] LineBcc    = 4'h6;
  localparam logic [3:0] LineMoveq  = 4'h7;
  localparam logic [3:0] LineOr     = 4'h8;
  localparam logic [3:0] LineSub    = 4'h9;
  localparam logic [3:0] LineCmp    = 4'hB;
  localparam logic [3:0] LineAnd    = 4'hC;
  localparam logic [3:0] LineAdd    = 4'hD;
  localparam logic [3:0] LineShift  = 4'hE;

  // Instructions waiting for the driver, and decodes waiting for the monitor.
  m68kpd_pkg::item_t instr_q[$];
  m68kpd_pkg::res_t  decode_q[$];

  int errors;
  bit stim_done;
  bit drain_hold;     // sender pauses until all decodes have come back
  int sink_hold;      // receiver holds off this many cycles (long stall)
  int src_gap;
  int snk_gap;

  // ---------------------------------------------------------------------------
  // Decode walker: state of one instruction while extension words are taken.
  // ---------------------------------------------------------------------------
  logic [15:0] wrd[5];
  int          avail;
  int          wofs;
  bit          walk_bad;
  logic [31:0] walk_base;
  bit          ea_tgt_ok;
  logic [31:0] ea_tgt;

  function automatic logic [31:0] take_word();
    if (wofs >= avail || wofs >= 5) begin
      walk_bad = 1'b1;
      return 32'd0;
    end
    wofs++;
    return {16'd0, wrd[wofs-1]};
  endfunction

  function automatic logic [31:0] take_long();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = take_word();
    lo = take_word();
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic logic [31:0] sext16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  // Walk one effective address; size SzLong means a long immediate.
  function automatic void walk_ea(logic [2:0] mode, logic [2:0] rg, logic [1:0] size);
    logic [31:0] pc;
    logic [31:0] dummy;
    ea_tgt_ok = 1'b0;
    ea_tgt    = '0;
    if (mode <= 3'd4) return;
    if (mode == 3'd5 || mode == 3'd6) begin
      dummy = take_word();
      return;
    end
    case (rg)
      3'd0, 3'd3: dummy = take_word();
      3'd1:       dummy = take_long();
      3'd2: begin
        pc        = walk_base + 32'(2 * wofs);
        ea_tgt    = pc + sext16(take_word());
        ea_tgt_ok = 1'b1;
      end
      3'd4: if (size == m68kpd_pkg::SzLong) dummy = take_long(); else dummy = take_word();
      default: walk_bad = 1'b1;
    endcase
  endfunction

  // Expected decode of one instruction.
  function automatic m68kpd_pkg::res_t decode_instr(m68kpd_pkg::item_t it);
    m68kpd_pkg::res_t r;
    logic [15:0] op;
    logic [2:0]  mode, rg, grp, opm;
    logic [1:0]  sz;
    logic [3:0]  cc;
    logic [31:0] pc, disp, dummy;
    bit          ok, br, call, ret, cnd, tok;
    logic [31:0] tgt;
    ok = 0; br = 0; call = 0; ret = 0; cnd = 0; tok = 0; tgt = '0;
    wrd[0] = it.opcode_word;    wrd[1] = it.ext_word_one;
    wrd[2] = it.ext_word_two;   wrd[3] = it.ext_word_three;
    wrd[4] = it.ext_word_four;
    avail     = (it.words_available > 3'd5) ? 5 : int'(it.words_available);
    wofs      = 0;
    walk_bad  = 1'b0;
    walk_base = it.address;
    op   = 16'(take_word());
    mode = op[5:3];
    rg   = op[2:0];
    sz   = op[7:6];
    if (!walk_bad) begin
      case (op[15:12])
        LineMoveB, LineMoveL, LineMoveW: begin
          logic [1:0] msz;
          msz = (op[15:12] == LineMoveB) ? m68kpd_pkg::SzByte :
                (op[15:12] == LineMoveL) ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord;
          walk_ea(mode, rg, msz);
          walk_ea(op[8:6], op[11:9], msz);
          ok = 1;
        end
        LineMoveq: ok = !op[8];
        LineBcc: begin
          cc   = op[11:8];
          pc   = walk_base + 32'(2 * wofs);
          disp = {{24{op[7]}}, op[7:0]};
          if (op[7:0] == 8'h00)      disp = sext16(take_word());
          else if (op[7:0] == 8'hFF) disp = take_long();
          tgt = pc + disp; tok = 1; br = 1;
          call = (cc == 4'd1);
          cnd  = (cc >= 4'd2);
          ok = 1;
        end
        LineQuick: begin
          if (sz == 2'd3) begin
            if (mode == 3'd1) begin
              pc  = walk_base + 32'(2 * wofs);
              tgt = pc + sext16(take_word());
              tok = 1; br = 1;
            end else walk_ea(mode, rg, m68kpd_pkg::SzByte);
            cnd = 1;
          end else walk_ea(mode, rg, sz);
          ok = 1;
        end
        LineBitImm: begin
          grp = op[11:9];
          if ((op & m68kpd_pkg::MaskMovep) == m68kpd_pkg::OpMovep) begin
            dummy = take_word(); ok = 1;
          end else if (op[8] || grp == 3'd4) begin
            if (grp == 3'd4 && !op[8]) dummy = take_word();
            walk_ea(mode, rg, (mode == 3'd0) ? m68kpd_pkg::SzLong : m68kpd_pkg::SzByte);
            ok = 1;
          end else if (grp != 3'd4 && grp != 3'd7 && sz != 2'd3) begin
            if (sz == m68kpd_pkg::SzLong) dummy = take_long(); else dummy = take_word();
            // immediate to CCR/SR takes no further word
            if (!(mode == 3'd7 && rg == 3'd4 &&
                  (grp == 3'd0 || grp == 3'd1 || grp == 3'd5) && sz <= 2'd1))
              walk_ea(mode, rg, sz);
            ok = 1;
          end
        end
        LineMisc: begin
          ok = 1;
          if ((op & 16'hFFF8) == m68kpd_pkg::OpLink) dummy = take_word();
          else if ((op & 16'hFFF8) == m68kpd_pkg::OpUnlk) ;
          else if ((op & 16'hFFF0) == m68kpd_pkg::OpTrap) ;
          else if (op == m68kpd_pkg::OpNop || op == m68kpd_pkg::OpReset ||
                   op == m68kpd_pkg::OpTrapv) ;
          else if (op == m68kpd_pkg::OpRte || op == m68kpd_pkg::OpRts ||
                   op == m68kpd_pkg::OpRtr) begin
            ret = 1; br = 1;
          end else if (op == m68kpd_pkg::OpStop) dummy = take_word();
          else if ((op & 16'hFFF0) == m68kpd_pkg::OpMoveUsp) ;
          else if ((op & 16'hFFC0) == m68kpd_pkg::OpJmp ||
                   (op & 16'hFFC0) == m68kpd_pkg::OpJsr) begin
            walk_ea(mode, rg, m68kpd_pkg::SzLong);
            tok = ea_tgt_ok; tgt = ea_tgt; br = 1;
            call = ((op & 16'hFFC0) == m68kpd_pkg::OpJsr);
          end
          else if ((op & 16'hFFF8) == m68kpd_pkg::OpSwap) ;
          else if ((op & 16'hFFB8) == m68kpd_pkg::OpExt) ;
          else if ((op & 16'hFFC0) == 16'h4840 || (op & 16'hF1C0) == m68kpd_pkg::OpLea)
            walk_ea(mode, rg, m68kpd_pkg::SzLong);
          else if ((op & m68kpd_pkg::MaskMovem) == m68kpd_pkg::OpMovem) begin
            dummy = take_word();
            walk_ea(mode, rg, op[6] ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord);
          end
          else if ((op & 16'hFFC0) == m68kpd_pkg::OpMoveSr ||
                   (op & 16'hFFC0) == m68kpd_pkg::OpMoveCcr ||
                   (op & 16'hFFC0) == m68kpd_pkg::OpMoveToSr)
            walk_ea(mode, rg, m68kpd_pkg::SzWord);
          else if (op[15:8] == 8'h42 || op[15:8] == 8'h44 ||
                   op[15:8] == 8'h40 || op[15:8] == 8'h46) begin
            if (sz == 2'd3) ok = 0; else walk_ea(mode, rg, sz);
          end
          else if (op[15:8] == 8'h4A)
            walk_ea(mode, rg, (sz == 2'd3) ? m68kpd_pkg::SzByte : sz);
          else if ((op & m68kpd_pkg::MaskChk) == m68kpd_pkg::OpChk)
            walk_ea(mode, rg, m68kpd_pkg::SzWord);
          else ok = 0;
        end
        LineOr, LineSub, LineCmp, LineAnd, LineAdd: begin
          logic [3:0] ln;
          ln  = op[15:12];
          opm = op[8:6];
          ok  = 1;
          if ((ln == LineSub || ln == LineAdd || ln == LineCmp) &&
              (opm == 3'd3 || opm == 3'd7))
            walk_ea(mode, rg, (opm == 3'd7) ? m68kpd_pkg::SzLong : m68kpd_pkg::SzWord);
          else if ((ln == LineAnd || ln == LineOr) && (opm == 3'd3 || opm == 3'd7))
            walk_ea(mode, rg, m68kpd_pkg::SzWord);
          else if (ln == LineAnd && (op & 16'h0130) == 16'h0100 &&
                   ((op & 16'hF8) == 16'h40 || (op & 16'hF8) == 16'h48 ||
                    (op & 16'hF8) == 16'h88)) ;    // EXG
          else if (ln == LineCmp && (op & 16'h0138) == 16'h0108) ;    // CMPM
          else if (ln == LineCmp && opm[2]) walk_ea(mode, rg, opm[1:0]);
          else if ((ln == LineSub || ln == LineAdd) && opm[2] && mode <= 3'd1) ; // ADDX/SUBX
          else if ((ln == LineAnd || ln == LineOr) && (op & 16'h01F0) == 16'h0100) ; // BCD
          else if (opm[1:0] != 2'd3) walk_ea(mode, rg, opm[1:0]);
          else ok = 0;
        end
        LineShift: begin
          if (sz == 2'd3) walk_ea(mode, rg, m68kpd_pkg::SzWord);
          ok = 1;
        end
        default: ok = 0;
      endcase
    end
    r = '0;
    if (!ok || walk_bad) begin
      r.length_bytes = 4'd2;
      return r;
    end
    r.length_bytes   = 4'(2 * wofs);
    r.valid_res      = 1'b1;
    r.is_branch      = br;
    r.is_call        = call;
    r.is_return      = ret;
    r.is_conditional = cnd;
    r.has_target     = tok;
    r.branch_target  = tok ? tgt : '0;
    return r;
  endfunction

  function automatic m68kpd_pkg::item_t mk_instr(logic [15:0] op, logic [2:0] n);
    m68kpd_pkg::item_t it;
    it.address         = $urandom;
    it.opcode_word     = op;
    it.ext_word_one    = 16'($urandom);
    it.ext_word_two    = 16'($urandom);
    it.ext_word_three  = 16'($urandom);
    it.ext_word_four   = 16'($urandom);
    it.words_available = n;
    return it;
  endfunction

  // Pick an opcode, mostly from the known groups, with random fields.
  function automatic logic [15:0] pick_opcode();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 13))
      0:  return (r & 16'h003F) | m68kpd_pkg::OpJmp;
      1:  return (r & 16'h003F) | m68kpd_pkg::OpJsr;
      2:  return {4'h6, r[11:0]};
      3:  return {4'h5, r[11:8], 2'b11, r[5:0]};
      4:  return 16'h4E70 | (r & 16'h0007);
      5:  return (r & 16'h047F) | m68kpd_pkg::OpMovem;
      6:  return (r & 16'h0E3F) | m68kpd_pkg::OpLea;
      7:  return {4'h0, r[11:0]};
      8:  return {2'b00, (r[13:12] == 2'b00) ? 2'b01 : r[13:12], r[11:0]};
      9:  return {8'h4A, r[7:0]};
      10: return {4'h4, r[11:0]};
      11: return {r[15:12], r[11:6], 3'b111, r[2:0]};
      default: return r;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4ms;
    $display("tb_m68000_instruction_predecoder_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued instructions, with random gaps and the drain pause.
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid = 1'b0;
    in_bus.address = '0; in_bus.opcode_word = '0;
    in_bus.ext_word_one = '0; in_bus.ext_word_two = '0;
    in_bus.ext_word_three = '0; in_bus.ext_word_four = '0;
    in_bus.words_available = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    m68kpd_pkg::item_t nx;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      // Drop the beat just taken and predict its decode.
      if (in_bus.valid && in_bus.ready) begin
        decode_q.push_back(decode_instr(instr_q.pop_front()));
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the offered beat
      end else if (src_gap > 0) begin
        src_gap      <= src_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (instr_q.size() == 0 || (drain_hold && decode_q.size() != 0) ||
                   (drain_hold && in_bus.valid)) begin
        in_bus.valid <= 1'b0;
      end else begin
        nx = instr_q[0];
        in_bus.valid           <= 1'b1;
        in_bus.address         <= nx.address;
        in_bus.opcode_word     <= nx.opcode_word;
        in_bus.ext_word_one    <= nx.ext_word_one;
        in_bus.ext_word_two    <= nx.ext_word_two;
        in_bus.ext_word_three  <= nx.ext_word_three;
        in_bus.ext_word_four   <= nx.ext_word_four;
        in_bus.words_available <= nx.words_available;
        // Next gap: mostly none, some short, a rare long one.
        case ($urandom_range(0, 19))
          0, 1, 2: src_gap <= $urandom_range(1, 3);
          3:       src_gap <= $urandom_range(10, 40);
          default: src_gap <= 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each decode with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    m68kpd_pkg::res_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      snk_gap       <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (decode_q.size() == 0) begin
          report_mismatch("unexpected decode beat", 32'(out_bus.length_bytes), 32'd0);
        end else begin
          want = decode_q.pop_front();
          if (out_bus.length_bytes !== want.length_bytes)
            report_mismatch("length_bytes", 32'(out_bus.length_bytes), 32'(want.length_bytes));
          if (out_bus.valid_res !== want.valid_res)
            report_mismatch("valid_res", 32'(out_bus.valid_res), 32'(want.valid_res));
          if (out_bus.is_branch !== want.is_branch)
            report_mismatch("is_branch", 32'(out_bus.is_branch), 32'(want.is_branch));
          if (out_bus.is_call !== want.is_call)
            report_mismatch("is_call", 32'(out_bus.is_call), 32'(want.is_call));
          if (out_bus.is_return !== want.is_return)
            report_mismatch("is_return", 32'(out_bus.is_return), 32'(want.is_return));
          if (out_bus.is_conditional !== want.is_conditional)
            report_mismatch("is_conditional", 32'(out_bus.is_conditional),
                            32'(want.is_conditional));
          if (out_bus.has_target !== want.has_target)
            report_mismatch("has_target", 32'(out_bus.has_target), 32'(want.has_target));
          if (out_bus.branch_target !== want.branch_target)
            report_mismatch("branch_target", out_bus.branch_target, want.branch_target);
        end
      end
      // Long hold-off first, then random stalls.
      if (sink_hold > 0) begin
        sink_hold     <= sink_hold - 1;
        out_bus.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap       <= snk_gap - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: snk_gap <= $urandom_range(1, 3);
          3:       snk_gap <= $urandom_range(10, 40);
          default: snk_gap <= 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random instructions.
  // ---------------------------------------------------------------------------
  initial begin
    m68kpd_pkg::item_t it;
    int    wait_cnt;
    errors     = 0;
    stim_done  = 0;
    drain_hold = 0;
    sink_hold  = 0;
    @(posedge rst_ni);

    // Directed: returns, jumps, long branch, DBcc, bad modes, short counts.
    instr_q.push_back(mk_instr(m68kpd_pkg::OpRts, 3'd1));
    instr_q.push_back(mk_instr(m68kpd_pkg::OpRte, 3'd5));
    instr_q.push_back(mk_instr(m68kpd_pkg::OpRtr, 3'd7));
    instr_q.push_back(mk_instr(m68kpd_pkg::OpRts, 3'd0));               // nothing present
    instr_q.push_back(mk_instr(m68kpd_pkg::OpJmp | 16'h003A, 3'd2));    // JMP d16(PC)
    instr_q.push_back(mk_instr(m68kpd_pkg::OpJsr | 16'h003A, 3'd1));    // too few words
    instr_q.push_back(mk_instr(m68kpd_pkg::OpJsr | 16'h0039, 3'd3));    // JSR abs.l
    instr_q.push_back(mk_instr(16'h61FF, 3'd3));            // BSR long
    instr_q.push_back(mk_instr(16'h6000, 3'd2));            // BRA word
    instr_q.push_back(mk_instr(16'h6780, 3'd1));            // BEQ short, negative
    instr_q.push_back(mk_instr(16'h51C8, 3'd6));            // DBF
    instr_q.push_back(mk_instr(16'h57C0, 3'd1));            // Scc Dn
    instr_q.push_back(mk_instr(16'h303D, 3'd5));            // mode 7 reg 5
    instr_q.push_back(mk_instr(16'h4A3E, 3'd5));            // mode 7 reg 6
    instr_q.push_back(mk_instr(16'h4A3F, 3'd5));            // mode 7 reg 7
    instr_q.push_back(mk_instr(16'hA000, 3'd5));            // line A
    instr_q.push_back(mk_instr(16'hFFFF, 3'd5));            // line F
    instr_q.push_back(mk_instr(16'h23F9, 3'd5));            // MOVE.L abs.l,abs.l
    instr_q.push_back(mk_instr(16'h003C, 3'd2));            // ORI to CCR
    instr_q.push_back(mk_instr(16'h0188, 3'd2));            // MOVEP
    instr_q.push_back(mk_instr(16'h48B9, 3'd4));            // MOVEM abs.l
    instr_q.push_back(mk_instr(16'h7100, 3'd1));            // bad MOVEQ
    instr_q.push_back(mk_instr(m68kpd_pkg::OpStop, 3'd1));
    it = mk_instr(16'h6000, 3'd2);
    it.address = 32'hFFFF_FFFE; it.ext_word_one = 16'h7FFF;
    instr_q.push_back(it);

    // Random: mostly known groups with random extension words.
    for (int n = 0; n < 850; n++) begin
      it = mk_instr(pick_opcode(), 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) != 0) it.words_available = 3'd5;
      instr_q.push_back(it);
      // Long receiver stall while the sender keeps offering.
      if (n == 200) sink_hold = 300;
      // Sender pause until all decodes are back.
      if (n == 500) begin
        drain_hold = 1;
        while (instr_q.size() != 0) @(posedge clk_i);
        wait_cnt = 0;
        while (decode_q.size() != 0 && wait_cnt < 100000) begin
          @(posedge clk_i);
          wait_cnt++;
        end
        drain_hold = 0;
      end
    end

    while (instr_q.size() != 0) @(posedge clk_i);
    wait_cnt = 0;
    while (decode_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0 && decode_q.size() == 0) begin
      $display("tb_m68000_instruction_predecoder_top OK");
    end else begin
      $display("tb_m68000_instruction_predecoder_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
